### design/sle_pkg.sv
package sle_pkg;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int LEN_W     = 5;
    localparam int SIZE_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int SEL_W     = 3;

    // Default depth of the character store.
    localparam int DEFAULT_LINE_DEPTH = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE   = 1'b1;

    // Configuration reset values.
    localparam logic              RESET_ECHO = 1'b1;
    localparam logic [SIZE_W-1:0] RESET_SIZE = 6'd32;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // Byte codes.
    localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] BYTE_DEL   = 8'h7f;
    localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] BYTE_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_TILDE = 8'h7e;

    // Sources of the result byte.
    localparam logic [SEL_W-1:0] SEL_ZERO = 3'd0;
    localparam logic [SEL_W-1:0] SEL_CR   = 3'd1;
    localparam logic [SEL_W-1:0] SEL_LF   = 3'd2;
    localparam logic [SEL_W-1:0] SEL_BS   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_SP   = 3'd4;
    localparam logic [SEL_W-1:0] SEL_RX   = 3'd5;
    localparam logic [SEL_W-1:0] SEL_MEM  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              rx_ready;
        logic              load_rx;
        logic              store_char;
        logic              cnt_dec;
        logic              cnt_clr;
        logic              idx_clr;
        logic              idx_inc;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic [SEL_W-1:0]  sel;
        logic              last;
    } sle_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_cr;
        logic is_del;
        logic is_print;
        logic has_room;
        logic echo_on;
        logic cnt_zero;
        logic idx_at_end;
        logic slot_free;
    } sle_status_t;

endpackage

### design/sle_rx_if.sv
interface sle_rx_if;
    logic                       valid;
    logic                       ready;
    logic [sle_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### design/sle_res_if.sv
interface sle_res_if;
    logic                       valid;
    logic                       ready;
    logic [sle_pkg::KIND_W-1:0] kind;
    logic [sle_pkg::BYTE_W-1:0] out_byte;
    logic [sle_pkg::LEN_W-1:0]  line_length;
    logic                       last;

    modport source (output valid, output kind, output out_byte, output line_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input line_length,
                    input last, output ready);
endinterface

### design/sle_ctrl.sv
module sle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    input  sle_pkg::sle_status_t status,
    output sle_pkg::sle_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_CR1    = 4'd2;
    localparam logic [3:0] ST_CR2    = 4'd3;
    localparam logic [3:0] ST_LF     = 4'd4;
    localparam logic [3:0] ST_REPLAY = 4'd5;
    localparam logic [3:0] ST_FIN    = 4'd6;
    localparam logic [3:0] ST_BS1    = 4'd7;
    localparam logic [3:0] ST_SP     = 4'd8;
    localparam logic [3:0] ST_BS2    = 4'd9;
    localparam logic [3:0] ST_PECHO  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = sle_pkg::KIND_ECHO;
        cmd.sel    = sle_pkg::SEL_ZERO;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.rx_ready = 1'b1;
                if (rx_valid)
                begin
                    cmd.load_rx = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (status.is_cr)
                begin
                    cmd.idx_clr = 1'b1;
                    if (status.echo_on)
                        state_next = ST_CR1;
                    else if (status.cnt_zero)
                        state_next = ST_FIN;
                    else
                        state_next = ST_REPLAY;
                end
                else if (status.is_del && !status.cnt_zero)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = status.echo_on ? ST_BS1 : ST_IDLE;
                end
                else if (status.is_print && status.has_room)
                begin
                    cmd.store_char = 1'b1;
                    state_next     = status.echo_on ? ST_PECHO : ST_IDLE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CR1:
            begin
                cmd.sel = sle_pkg::SEL_CR;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CR2;
                end
            end
            ST_CR2:
            begin
                cmd.sel = sle_pkg::SEL_CR;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_LF;
                end
            end
            ST_LF:
            begin
                cmd.sel = sle_pkg::SEL_LF;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.cnt_zero ? ST_FIN : ST_REPLAY;
                end
            end
            ST_REPLAY:
            begin
                cmd.kind = sle_pkg::KIND_CHAR;
                cmd.sel  = sle_pkg::SEL_MEM;
                if (status.slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.idx_inc = 1'b1;
                    if (status.idx_at_end)
                        state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.kind = sle_pkg::KIND_END;
                cmd.last = 1'b1;
                if (status.slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_BS1:
            begin
                cmd.sel = sle_pkg::SEL_BS;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_SP;
                end
            end
            ST_SP:
            begin
                cmd.sel = sle_pkg::SEL_SP;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_BS2;
                end
            end
            ST_BS2:
            begin
                cmd.sel  = sle_pkg::SEL_BS;
                cmd.last = 1'b1;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PECHO:
            begin
                cmd.sel  = sle_pkg::SEL_RX;
                cmd.last = 1'b1;
                if (status.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/sle_datapath.sv
module sle_datapath #(
    parameter int LINE_DEPTH = sle_pkg::DEFAULT_LINE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sle_pkg::SIZE_W-1:0]    cfg_data,
    input  logic [sle_pkg::BYTE_W-1:0]    rx_byte,
    input  logic                          res_ready,
    input  sle_pkg::sle_cmd_t             cmd,
    output sle_pkg::sle_status_t          status,
    output logic                          res_valid,
    output logic [sle_pkg::KIND_W-1:0]    res_kind,
    output logic [sle_pkg::BYTE_W-1:0]    res_byte,
    output logic [sle_pkg::LEN_W-1:0]     res_len,
    output logic                          res_last
);

    localparam int CW = $clog2(LINE_DEPTH);
    localparam int WW = sle_pkg::SIZE_W + 1;
    localparam logic [sle_pkg::SIZE_W-1:0] DEPTH_SZ = sle_pkg::SIZE_W'(LINE_DEPTH);

    logic                          echo_reg;
    logic [sle_pkg::SIZE_W-1:0]    size_reg;
    logic [sle_pkg::BYTE_W-1:0]    rx_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [CW-1:0]                 idx_reg;
    logic [CW-1:0]                 idx_next;
    logic [sle_pkg::BYTE_W-1:0]    mem [LINE_DEPTH];
    logic [sle_pkg::BYTE_W-1:0]    rd_data_reg;
    logic                          out_valid_reg;
    logic [sle_pkg::KIND_W-1:0]    out_kind_reg;
    logic [sle_pkg::BYTE_W-1:0]    out_byte_reg;
    logic [sle_pkg::LEN_W-1:0]     out_len_reg;
    logic                          out_last_reg;
    logic [sle_pkg::SIZE_W-1:0]    size_eff;
    logic [WW-1:0]                 cnt_wide;
    logic [WW-1:0]                 idx_wide;
    logic [sle_pkg::BYTE_W-1:0]    byte_mux;
    logic                          slot_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg <= sle_pkg::RESET_ECHO;
            size_reg <= sle_pkg::RESET_SIZE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sle_pkg::CFG_ECHO_ENABLE: echo_reg <= cfg_data[0];
                sle_pkg::CFG_LINE_SIZE:   size_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Received byte holding register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_rx)
            rx_reg <= rx_byte;
    end

    // Character count and replay index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            priority if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - CW'(1);
            else if (cmd.store_char)
                cnt_reg <= cnt_reg + CW'(1);
            idx_reg <= idx_next;
        end
    end

    always_comb
    begin
        priority if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + CW'(1);
        else
            idx_next = idx_reg;
    end

    // Character store; the read follows the next replay index so the
    // registered data always matches the current index.
    always_ff @(posedge clk)
    begin
        if (cmd.store_char)
            mem[cnt_reg] <= rx_reg;
        rd_data_reg <= mem[idx_next];
    end

    // Status toward the controller.
    assign size_eff = (size_reg > DEPTH_SZ) ? DEPTH_SZ : size_reg;
    assign cnt_wide = WW'(cnt_reg);
    assign idx_wide = WW'(idx_reg);
    assign slot_free = !out_valid_reg || res_ready;

    always_comb
    begin
        status.is_cr      = (rx_reg == sle_pkg::BYTE_CR);
        status.is_del     = (rx_reg == sle_pkg::BYTE_DEL);
        status.is_print   = (rx_reg >= sle_pkg::BYTE_SP) && (rx_reg <= sle_pkg::BYTE_TILDE);
        status.has_room   = (cnt_wide + WW'(1)) < WW'(size_eff);
        status.echo_on    = echo_reg;
        status.cnt_zero   = (cnt_reg == '0);
        status.idx_at_end = (idx_wide + WW'(1)) == cnt_wide;
        status.slot_free  = slot_free;
    end

    // Result byte selection.
    always_comb
    begin
        unique case (cmd.sel)
            sle_pkg::SEL_CR:  byte_mux = sle_pkg::BYTE_CR;
            sle_pkg::SEL_LF:  byte_mux = sle_pkg::BYTE_LF;
            sle_pkg::SEL_BS:  byte_mux = sle_pkg::BYTE_BS;
            sle_pkg::SEL_SP:  byte_mux = sle_pkg::BYTE_SP;
            sle_pkg::SEL_RX:  byte_mux = rx_reg;
            sle_pkg::SEL_MEM: byte_mux = rd_data_reg;
            default:          byte_mux = '0;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.kind;
            out_byte_reg <= byte_mux;
            out_len_reg  <= (cmd.kind == sle_pkg::KIND_END) ?
                            cnt_wide[sle_pkg::LEN_W-1:0] : '0;
            out_last_reg <= cmd.last;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_kind  = out_kind_reg;
    assign res_byte  = out_byte_reg;
    assign res_len   = out_len_reg;
    assign res_last  = out_last_reg;

endmodule

### design/serial_line_editor_unit.sv
// Channel | Dir | Payload                              | Accepted when
// rx      | in  | rx_byte                              | rx.valid && rx.ready
// res     | out | kind, out_byte, line_length, last    | res.valid && res.ready
// cfg     | in  | cfg_index, cfg_data                  | cfg_we
//
// An item is accepted only while the controller is idle; it is decoded in
// the next cycle, and its results then leave at one per cycle through the
// output register, as long as the receiver keeps that register free. Replay
// reads the line through the single read port of the store.
// Reset clears the count, the controller and the output valid; the store
// holds no reset. A stalled output register holds the sequence in place.
module serial_line_editor_unit #(
    parameter int LINE_DEPTH = sle_pkg::DEFAULT_LINE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sle_pkg::SIZE_W-1:0]    cfg_data,
    sle_rx_if.sink                        rx,
    sle_res_if.source                     res
);

    sle_pkg::sle_cmd_t    cmd;
    sle_pkg::sle_status_t status;

    // Sequencing of echo, replay and end marker.
    sle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .status   (status),
        .cmd      (cmd)
    );

    assign rx.ready = cmd.rx_ready;

    // Line store, count and result register.
    sle_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (rx.rx_byte),
        .res_ready (res.ready),
        .cmd       (cmd),
        .status    (status),
        .res_valid (res.valid),
        .res_kind  (res.kind),
        .res_byte  (res.out_byte),
        .res_len   (res.line_length),
        .res_last  (res.last)
    );

endmodule

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH   = sle_pkg::DEFAULT_LINE_DEPTH;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;
    localparam int STALL_CYCLES = 300;

    // One result of the editor, in port order.
    typedef struct packed {
        logic [sle_pkg::KIND_W-1:0] kind;
        logic [sle_pkg::BYTE_W-1:0] out_byte;
        logic [sle_pkg::LEN_W-1:0]  line_length;
        logic                       last;
    } editor_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [sle_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sle_pkg::SIZE_W-1:0]    cfg_data;

    sle_rx_if  rx_ch ();
    sle_res_if res_ch ();

    serial_line_editor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    // Shadow copy of the line buffer, its count and the two registers.
    logic [sle_pkg::BYTE_W-1:0] line_chars [LINE_DEPTH];
    int                         held_count;
    logic                       echo_on;
    logic [sle_pkg::SIZE_W-1:0] size_setting;

    // Echo bytes, line contents and end markers still owed by the editor, oldest first.
    editor_result_t    owed_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;
    int cycles_run;
    int items_sent;
    int results_seen;
    int lines_closed;
    int mismatches;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle budget for the whole run.
    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycles_run,
                     owed_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic editor_result_t make_result(
        input logic [sle_pkg::KIND_W-1:0] kind,
        input logic [sle_pkg::BYTE_W-1:0] b,
        input logic [sle_pkg::LEN_W-1:0]  len);
        return '{kind, b, len, 1'b0};
    endfunction

    // Apply one received byte to the shadow line and queue what it must produce.
    function automatic void predict_line_edit(input logic [sle_pkg::BYTE_W-1:0] b);
        editor_result_t batch [$];
        int             usable;
        int             room;
        int             i;
        usable = (size_setting > LINE_DEPTH) ? LINE_DEPTH : int'(size_setting);
        room   = (usable == 0) ? 0 : usable - 1;
        if (b == sle_pkg::BYTE_CR)
        begin
            if (echo_on)
            begin
                batch.push_back(make_result(sle_pkg::KIND_ECHO, sle_pkg::BYTE_CR, '0));
                batch.push_back(make_result(sle_pkg::KIND_ECHO, sle_pkg::BYTE_CR, '0));
                batch.push_back(make_result(sle_pkg::KIND_ECHO, sle_pkg::BYTE_LF, '0));
            end
            for (i = 0; i < held_count; i++)
                batch.push_back(make_result(sle_pkg::KIND_CHAR, line_chars[i], '0));
            batch.push_back(make_result(sle_pkg::KIND_END, '0,
                                        sle_pkg::LEN_W'(held_count)));
            held_count = 0;
            lines_closed++;
        end
        else if (b == sle_pkg::BYTE_DEL)
        begin
            if (held_count > 0)
            begin
                held_count--;
                if (echo_on)
                begin
                    batch.push_back(make_result(sle_pkg::KIND_ECHO, sle_pkg::BYTE_BS, '0));
                    batch.push_back(make_result(sle_pkg::KIND_ECHO, sle_pkg::BYTE_SP, '0));
                    batch.push_back(make_result(sle_pkg::KIND_ECHO, sle_pkg::BYTE_BS, '0));
                end
            end
        end
        else if (b >= sle_pkg::BYTE_SP && b <= sle_pkg::BYTE_TILDE)
        begin
            if (held_count < room)
            begin
                line_chars[held_count] = b;
                held_count++;
                if (echo_on)
                    batch.push_back(make_result(sle_pkg::KIND_ECHO, b, '0));
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            owed_results.push_back(batch[k]);
    endfunction

    function automatic void report_mismatch(input string what, input editor_result_t want,
                                            input editor_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t: %s: expected kind=%0d byte=%02h len=%0d last=%0d",
                     $realtime, what, want.kind, want.out_byte, want.line_length, want.last);
            $display("    got kind=%0d byte=%02h len=%0d last=%0d",
                     got.kind, got.out_byte, got.line_length, got.last);
        end
    endfunction

    // Receiver: random ready, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every accepted result with the oldest one owed.
    always @(posedge clk)
    begin
        editor_result_t got;
        editor_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.kind, res_ch.out_byte, res_ch.line_length, res_ch.last};
            results_seen++;
            if (owed_results.size() == 0)
                report_mismatch("result with nothing owed", '0, got);
            else
            begin
                want = owed_results.pop_front();
                if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                    got.line_length !== want.line_length || got.last !== want.last)
                    report_mismatch("wrong result", want, got);
            end
        end
    end

    // Offer one byte, wait until it is taken, then maybe idle for a while.
    task automatic send_byte(input logic [sle_pkg::BYTE_W-1:0] b);
        int idle;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        predict_line_edit(b);
        items_sent++;
        idle = 0;
        while ($urandom_range(99) < send_idle_pct)
            idle++;
        if (idle > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    // Stop offering, collect everything owed, and let a silent item finish.
    task automatic quiesce();
        rx_ch.valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sle_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sle_pkg::SIZE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == sle_pkg::CFG_ECHO_ENABLE)
            echo_on = value[0];
        else
            size_setting = value;
        @(posedge clk);
    endtask

    function automatic logic [sle_pkg::SIZE_W-1:0] pick_line_size();
        case ($urandom_range(7))
            0:       return sle_pkg::SIZE_W'(0);
            1:       return sle_pkg::SIZE_W'(1);
            2:       return sle_pkg::SIZE_W'(2);
            3:       return sle_pkg::SIZE_W'(31);
            4:       return sle_pkg::SIZE_W'(32);
            5:       return sle_pkg::SIZE_W'(33);
            6:       return sle_pkg::SIZE_W'(63);
            default: return sle_pkg::SIZE_W'($urandom_range(63));
        endcase
    endfunction

    // Ignored bytes, DEL on an empty line, typing, erasing and empty lines.
    task automatic test_basic_editing();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(sle_pkg::BYTE_LF);
        send_byte(sle_pkg::BYTE_DEL);
        send_byte(sle_pkg::BYTE_SP);
        send_byte(sle_pkg::BYTE_TILDE);
        send_byte(8'h41);
        send_byte(sle_pkg::BYTE_DEL);
        send_byte(sle_pkg::BYTE_CR);
        send_byte(sle_pkg::BYTE_CR);
    endtask

    // A full line drops further bytes; sizes one and zero keep nothing.
    task automatic test_full_and_tiny_lines();
        quiesce();
        write_reg(sle_pkg::CFG_LINE_SIZE, sle_pkg::SIZE_W'(3));
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(8'h63);
        send_byte(sle_pkg::BYTE_CR);
        quiesce();
        write_reg(sle_pkg::CFG_LINE_SIZE, sle_pkg::SIZE_W'(1));
        send_byte(8'h78);
        quiesce();
        write_reg(sle_pkg::CFG_LINE_SIZE, sle_pkg::SIZE_W'(0));
        send_byte(8'h79);
        send_byte(sle_pkg::BYTE_CR);
    endtask

    // No echo, a size above the store depth, then a size lowered under the count.
    task automatic test_silent_shrunk_line();
        quiesce();
        write_reg(sle_pkg::CFG_ECHO_ENABLE, sle_pkg::SIZE_W'(0));
        write_reg(sle_pkg::CFG_LINE_SIZE, sle_pkg::SIZE_W'(63));
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(8'h63);
        quiesce();
        write_reg(sle_pkg::CFG_LINE_SIZE, sle_pkg::SIZE_W'(2));
        send_byte(8'h64);
        send_byte(sle_pkg::BYTE_DEL);
        send_byte(sle_pkg::BYTE_DEL);
        send_byte(8'h66);
        send_byte(sle_pkg::BYTE_DEL);
        send_byte(8'h67);
        send_byte(sle_pkg::BYTE_CR);
    endtask

    // Sessions of random settings, mostly typed lines closed by CR, some noise.
    task automatic test_random_lines(input int sessions, input int per_session);
        int                         s;
        int                         sent;
        int                         pick;
        int                         len;
        int                         j;
        int                         dels;
        logic [sle_pkg::BYTE_W-1:0] b;
        for (s = 0; s < sessions; s++)
        begin
            quiesce();
            write_reg(sle_pkg::CFG_ECHO_ENABLE, sle_pkg::SIZE_W'($urandom_range(1)));
            write_reg(sle_pkg::CFG_LINE_SIZE, pick_line_size());
            sent = 0;
            while (sent < per_session)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 8);
                    for (j = 0; j < len; j++)
                    begin
                        if ($urandom_range(9) == 0)
                            b = sle_pkg::BYTE_DEL;
                        else
                            b = sle_pkg::BYTE_W'($urandom_range(sle_pkg::BYTE_SP,
                                                                sle_pkg::BYTE_TILDE));
                        send_byte(b);
                    end
                    send_byte(sle_pkg::BYTE_CR);
                    sent += len + 1;
                end
                else if (pick < 90)
                begin
                    b = sle_pkg::BYTE_W'($urandom_range(255));
                    send_byte(b);
                    sent++;
                end
                else
                begin
                    dels = $urandom_range(1, 4);
                    repeat (dels) send_byte(sle_pkg::BYTE_DEL);
                    sent += dels;
                end
            end
        end
    endtask

    // Receiver holds off long enough for the editor to fill and stop taking bytes,
    // then the longest possible line is closed.
    task automatic test_receiver_stall();
        int j;
        quiesce();
        write_reg(sle_pkg::CFG_ECHO_ENABLE, sle_pkg::SIZE_W'(1));
        write_reg(sle_pkg::CFG_LINE_SIZE, sle_pkg::SIZE_W'(32));
        stall_left = STALL_CYCLES;
        for (j = 0; j < LINE_DEPTH + 3; j++)
            send_byte(sle_pkg::BYTE_W'($urandom_range(sle_pkg::BYTE_SP, sle_pkg::BYTE_TILDE)));
        send_byte(sle_pkg::BYTE_CR);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = sle_pkg::CFG_ECHO_ENABLE;
        cfg_data       = '0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        res_ch.ready   = 1'b0;
        held_count     = 0;
        echo_on        = sle_pkg::RESET_ECHO;
        size_setting   = sle_pkg::RESET_SIZE;
        send_idle_pct  = 25;
        recv_idle_pct  = 67;
        stall_left     = 0;
        cycles_run     = 0;
        items_sent     = 0;
        results_seen   = 0;
        lines_closed   = 0;
        mismatches     = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_editing();
        test_full_and_tiny_lines();
        test_silent_shrunk_line();
        test_random_lines(4, 16);

        send_idle_pct = 67;
        recv_idle_pct = 25;
        test_random_lines(4, 16);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lines(4, 16);
        test_receiver_stall();

        quiesce();
        $display("Sent %0d bytes and checked %0d results over %0d completed lines,",
                 items_sent, results_seen, lines_closed);
        $display("with echo on and off, line sizes 0 to 63 and a long receiver hold-off.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### serial_line_editor_unit.f
design/sle_pkg.sv
design/sle_rx_if.sv
design/sle_res_if.sv
design/sle_ctrl.sv
design/sle_datapath.sv
design/serial_line_editor_unit.sv
bench/testbench.sv
